// ----- rtl/vsp_pkg.sv -----
// Shared types, codes and fixed-point helpers for the vertex screen projection block.
// Used by every module of the block; depends on nothing.
package vsp_pkg;

  localparam int RECIP_BITS = 49;
  localparam int ADDR_W     = 5;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SCALE_X  = 3'd1;
  localparam logic [2:0] REG_SCALE_Y  = 3'd2;
  localparam logic [2:0] REG_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DEPTH = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  localparam logic [31:0] RST_SCALE_X = 32'h0001_0000;
  localparam logic [31:0] RST_SCALE_Y = 32'hFFFF_0000;
  localparam logic [31:0] RST_INV_Z   = 32'd429497;

  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_depth;
    logic [31:0] cam_up;
    logic        persp;
    logic        bad;
  } vtx_t;

  typedef struct packed {
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [32:0] screen_depth;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  // returns {saturated, value}
  function automatic logic [32:0] from_mag(logic neg, logic [63:0] m);
    logic        s;
    logic [31:0] v;
    s = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s = 1'b1;
        v = 32'h8000_0000;
      end else begin
        v = 32'd0 - m[31:0];
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        s = 1'b1;
        v = 32'h7FFF_FFFF;
      end else begin
        v = m[31:0];
      end
    end
    from_mag = {s, v};
  endfunction

  function automatic logic [32:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = {1'b1, (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      sat_add = {1'b0, s[31:0]};
    end
  endfunction

endpackage

// ----- rtl/vertex_screen_projection_core.sv -----
// Top level of the vertex screen projection block: register port, pipeline and output skid.
// Depends on vsp_pkg, vsp_recip and vsp_project.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | cam_x, cam_depth, cam_up
//  out     | output    | out_valid / out_stall| screen_x, screen_y, screen_depth, status
//  cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// One item per cycle while in_stall is low; path: 49 reciprocal stages, 4 projection stages, output register.
// rst is synchronous and clears all valid bits and the registers to their defaults.
// A stalled result waits in the output register; the next one parks in the skid slot,
// and in_stall rises only while that slot is occupied.
module vertex_screen_projection_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 cam_x,
  input  logic [31:0]                 cam_depth,
  input  logic [31:0]                 cam_up,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 screen_x,
  output logic [31:0]                 screen_y,
  output logic [32:0]                 screen_depth,
  output logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic        perspective_mode;
  logic [31:0] scale_x, scale_y, offset_x, offset_y, inv_z_adjust;

  logic [2:0]  reg_idx;
  logic        en;
  vsp_pkg::vtx_t in_vtx, rc_vtx;
  logic        rc_vld, pj_vld;
  logic [vsp_pkg::RECIP_BITS-1:0] rc_recip;
  vsp_pkg::res_t pj_res, out_res, skid_res;
  logic        skid_valid;

  assign reg_idx = paddr[vsp_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perspective_mode <= 1'b1;
      scale_x          <= vsp_pkg::RST_SCALE_X;
      scale_y          <= vsp_pkg::RST_SCALE_Y;
      offset_x         <= '0;
      offset_y         <= '0;
      inv_z_adjust     <= vsp_pkg::RST_INV_Z;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        vsp_pkg::REG_MODE:     perspective_mode <= pwdata[0];
        vsp_pkg::REG_SCALE_X:  scale_x          <= pwdata;
        vsp_pkg::REG_SCALE_Y:  scale_y          <= pwdata;
        vsp_pkg::REG_OFFSET_X: offset_x         <= pwdata;
        vsp_pkg::REG_OFFSET_Y: offset_y         <= pwdata;
        vsp_pkg::REG_INV_Z:    inv_z_adjust     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      vsp_pkg::REG_MODE:     prdata = {31'd0, perspective_mode};
      vsp_pkg::REG_SCALE_X:  prdata = scale_x;
      vsp_pkg::REG_SCALE_Y:  prdata = scale_y;
      vsp_pkg::REG_OFFSET_X: prdata = offset_x;
      vsp_pkg::REG_OFFSET_Y: prdata = offset_y;
      vsp_pkg::REG_INV_Z:    prdata = inv_z_adjust;
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    in_vtx.cam_x     = cam_x;
    in_vtx.cam_depth = cam_depth;
    in_vtx.cam_up    = cam_up;
    in_vtx.persp     = perspective_mode;
    in_vtx.bad       = perspective_mode && (cam_depth[31] || (cam_depth == 32'd0));
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  vsp_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (in_valid),
    .in_vtx    (in_vtx),
    .out_vld   (rc_vld),
    .out_vtx   (rc_vtx),
    .out_recip (rc_recip)
  );

  vsp_project u_project (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (rc_vld),
    .in_vtx       (rc_vtx),
    .in_recip     (rc_recip),
    .scale_x      (scale_x),
    .scale_y      (scale_y),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .inv_z_adjust (inv_z_adjust),
    .out_vld      (pj_vld),
    .out_res      (pj_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      skid_valid <= pj_vld;
    end else begin
      out_valid <= pj_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_res <= skid_res;
      end
    end else if (out_valid && out_stall) begin
      skid_res <= pj_res;
    end else begin
      out_res <= pj_res;
    end
  end

  assign screen_x     = out_res.screen_x;
  assign screen_y     = out_res.screen_y;
  assign screen_depth = out_res.screen_depth;
  assign status       = out_res.status;

endmodule

// ----- rtl/vsp_recip.sv -----
// Pipelined restoring divider forming floor(2^48 / depth), one quotient bit per stage.
// Carries the vertex alongside; depends on vsp_pkg.
module vsp_recip (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  vsp_pkg::vtx_t                       in_vtx,
  output logic                                out_vld,
  output vsp_pkg::vtx_t                       out_vtx,
  output logic [vsp_pkg::RECIP_BITS-1:0]      out_recip
);

  localparam int RB = vsp_pkg::RECIP_BITS;

  logic                vld [RB];
  vsp_pkg::vtx_t       vtx [RB];
  logic [31:0]         rem [RB];
  logic [RB-1:0]       quo [RB];
  logic [30:0]         dvs [RB];

  genvar k;
  generate
    for (k = 0; k < RB; k++) begin : g_stage
      logic [31:0]   rem_prev;
      logic [RB-1:0] quo_prev;
      logic [30:0]   dvs_k;
      logic          vld_prev;
      vsp_pkg::vtx_t vtx_prev;
      logic          dbit;
      logic [31:0]   rem_sh;
      logic          ge;

      if (k == 0) begin : g_first
        always_comb begin
          rem_prev = '0;
          quo_prev = '0;
          dbit     = 1'b1;
          vld_prev = in_vld;
          vtx_prev = in_vtx;
          if (in_vtx.cam_depth[31] || (in_vtx.cam_depth == 32'd0)) begin
            dvs_k = 31'd1;
          end else begin
            dvs_k = in_vtx.cam_depth[30:0];
          end
        end
      end else begin : g_next
        always_comb begin
          rem_prev = rem[k-1];
          quo_prev = quo[k-1];
          dbit     = 1'b0;
          vld_prev = vld[k-1];
          vtx_prev = vtx[k-1];
          dvs_k    = dvs[k-1];
        end
      end

      always_comb begin
        rem_sh = {rem_prev[30:0], dbit};
        ge     = (rem_sh >= {1'b0, dvs_k});
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld_prev;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          vtx[k] <= vtx_prev;
          dvs[k] <= dvs_k;
          rem[k] <= ge ? (rem_sh - {1'b0, dvs_k}) : rem_sh;
          quo[k] <= {quo_prev[RB-2:0], ge};
        end
      end
    end
  endgenerate

  assign out_vld   = vld[RB-1];
  assign out_vtx   = vtx[RB-1];
  assign out_recip = quo[RB-1];

endmodule

// ----- rtl/vsp_project.sv -----
// Four-stage multiply, scale, offset and saturate pipeline after the reciprocal.
// Depends on vsp_pkg; fed by vsp_recip.
module vsp_project (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  vsp_pkg::vtx_t                  in_vtx,
  input  logic [vsp_pkg::RECIP_BITS-1:0] in_recip,
  input  logic [31:0]                    scale_x,
  input  logic [31:0]                    scale_y,
  input  logic [31:0]                    offset_x,
  input  logic [31:0]                    offset_y,
  input  logic [31:0]                    inv_z_adjust,
  output logic                           out_vld,
  output vsp_pkg::res_t                  out_res
);

  localparam int HB = vsp_pkg::RECIP_BITS - 32;

  // stage 1: partial products
  logic          p1_vld;
  vsp_pkg::vtx_t p1_vtx;
  logic [63:0]   p1_xlo, p1_zlo, p1_dlo;
  logic [HB+31:0] p1_xhi, p1_zhi, p1_dhi;

  // stage 2: recombine, first saturation
  logic          p2_vld;
  vsp_pkg::vtx_t p2_vtx;
  logic [31:0]   p2_qx, p2_qz;
  logic [32:0]   p2_depth;
  logic          p2_sat;

  // stage 3: scale products
  logic          p3_vld;
  logic          p3_bad;
  logic [63:0]   p3_px, p3_pz;
  logic          p3_nx, p3_nz;
  logic [32:0]   p3_depth;
  logic          p3_sat;

  logic          p4_vld;

  logic [31:0]   mx_a, mz_a;
  logic [HB+32:0] sx, sz, sd;
  logic [32:0]   fx, fz, tx, tz, ax, az;
  logic          dsat;
  logic [31:0]   dval;

  always_comb begin
    mx_a = vsp_pkg::mag32(in_vtx.cam_x);
    mz_a = vsp_pkg::mag32(in_vtx.cam_up);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_vtx <= in_vtx;
      p1_xlo <= mx_a * in_recip[31:0];
      p1_xhi <= mx_a * in_recip[vsp_pkg::RECIP_BITS-1:32];
      p1_zlo <= mz_a * in_recip[31:0];
      p1_zhi <= mz_a * in_recip[vsp_pkg::RECIP_BITS-1:32];
      p1_dlo <= inv_z_adjust * in_recip[31:0];
      p1_dhi <= inv_z_adjust * in_recip[vsp_pkg::RECIP_BITS-1:32];
    end
  end

  always_comb begin
    sx   = {1'b0, p1_xhi} + {{(HB+1){1'b0}}, p1_xlo[63:32]};
    sz   = {1'b0, p1_zhi} + {{(HB+1){1'b0}}, p1_zlo[63:32]};
    sd   = {1'b0, p1_dhi} + {{(HB+1){1'b0}}, p1_dlo[63:32]};
    fx   = vsp_pkg::from_mag(p1_vtx.cam_x[31], {{(31-HB){1'b0}}, sx});
    fz   = vsp_pkg::from_mag(p1_vtx.cam_up[31], {{(31-HB){1'b0}}, sz});
    dsat = (sd[HB+32:32] != '0);
    dval = dsat ? 32'hFFFF_FFFF : sd[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_vtx <= p1_vtx;
      if (p1_vtx.persp) begin
        p2_qx    <= fx[31:0];
        p2_qz    <= fz[31:0];
        p2_depth <= {1'b0, dval};
        p2_sat   <= fx[32] | fz[32] | dsat;
      end else begin
        p2_qx    <= p1_vtx.cam_x;
        p2_qz    <= p1_vtx.cam_up;
        p2_depth <= {p1_vtx.cam_depth[31], p1_vtx.cam_depth};
        p2_sat   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_px    <= vsp_pkg::mag32(p2_qx) * vsp_pkg::mag32(scale_x);
      p3_pz    <= vsp_pkg::mag32(p2_qz) * vsp_pkg::mag32(scale_y);
      p3_nx    <= p2_qx[31] ^ scale_x[31];
      p3_nz    <= p2_qz[31] ^ scale_y[31];
      p3_depth <= p2_depth;
      p3_sat   <= p2_sat;
      p3_bad   <= p2_vtx.bad;
    end
  end

  always_comb begin
    tx = vsp_pkg::from_mag(p3_nx, {16'd0, p3_px[63:16]});
    tz = vsp_pkg::from_mag(p3_nz, {16'd0, p3_pz[63:16]});
    ax = vsp_pkg::sat_add(tx[31:0], offset_x);
    az = vsp_pkg::sat_add(tz[31:0], offset_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p3_bad) begin
        out_res.screen_x     <= '0;
        out_res.screen_y     <= '0;
        out_res.screen_depth <= '0;
        out_res.status       <= vsp_pkg::STAT_DEPTH;
      end else begin
        out_res.screen_x     <= ax[31:0];
        out_res.screen_y     <= az[31:0];
        out_res.screen_depth <= p3_depth;
        out_res.status       <= (p3_sat | tx[32] | tz[32] | ax[32] | az[32]) ?
                                vsp_pkg::STAT_SAT : vsp_pkg::STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= in_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  assign out_vld = p4_vld;

endmodule

// ----- rtl/vsp_checker.sv -----
// Port-level checks for the vertex screen projection block, bound to the top level.
// Depends on vsp_pkg and vertex_screen_projection_core.
module vsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y,
  input logic [32:0] screen_depth,
  input logic [1:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(status))
    else $error("stalled item changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == vsp_pkg::STAT_DEPTH) |->
      (screen_x == 32'd0) && (screen_y == 32'd0) && (screen_depth == 33'd0))
    else $error("rejected depth gave nonzero outputs");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == vsp_pkg::STAT_OK) || (status == vsp_pkg::STAT_DEPTH) ||
                  (status == vsp_pkg::STAT_SAT))
    else $error("undefined status");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output live after reset");

endmodule

bind vertex_screen_projection_core vsp_checker u_vsp_checker (.*);

// ----- bench/tb_vertex_screen_projection_core.sv -----
// Testbench for vertex_screen_projection_core: perspective and parallel projection of vertices.
// Holds a scoreboard class that predicts each result; depends on vsp_pkg and the block's RTL.
module tb_vertex_screen_projection_core;

  localparam int STALL_LIMIT = 3000;

  class projection_scoreboard;
    logic        persp;
    logic [31:0] sx, sy, ox, oy, adj;
    bit          clipped;
    vsp_pkg::res_t pending[$];
    int          errors;

    function new();
      persp = 1'b1;
      sx = vsp_pkg::RST_SCALE_X;
      sy = vsp_pkg::RST_SCALE_Y;
      ox = 32'd0;
      oy = 32'd0;
      adj = vsp_pkg::RST_INV_Z;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        vsp_pkg::REG_MODE:     persp = v[0];
        vsp_pkg::REG_SCALE_X:  sx = v;
        vsp_pkg::REG_SCALE_Y:  sy = v;
        vsp_pkg::REG_OFFSET_X: ox = v;
        vsp_pkg::REG_OFFSET_Y: oy = v;
        vsp_pkg::REG_INV_Z:    adj = v;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        clipped = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function logic [63:0] abs64(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function longint signed_of(bit neg, logic [63:0] m);
      return neg ? clamp32(-longint'(m)) : clamp32(longint'(m));
    endfunction

    function longint axis(logic [31:0] c, logic [31:0] sc, logic [31:0] off,
                          logic [63:0] r);
      longint      cv, q, t;
      logic [63:0] ma, m;
      cv = longint'($signed(c));
      q = cv;
      if (persp) begin
        ma = abs64(cv);
        m = ma * (r >> 32) + ((ma * {32'd0, r[31:0]}) >> 32);
        q = signed_of(cv < 0, m);
      end
      m = (abs64(q) * abs64(longint'($signed(sc)))) >> 16;
      t = signed_of((q < 0) != ($signed(sc) < 0), m);
      return clamp32(t + longint'($signed(off)));
    endfunction

    function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vsp_pkg::res_t e;
      logic [63:0] r, d;
      longint      yv;
      clipped = 1'b0;
      r = 64'd0;
      yv = longint'($signed(y));
      if (persp && yv <= 0) begin
        e = '{screen_x: 32'd0, screen_y: 32'd0, screen_depth: 33'd0,
              status: vsp_pkg::STAT_DEPTH};
        pending.push_back(e);
        return;
      end
      if (persp) begin
        r = 64'h0001_0000_0000_0000 / 64'(yv);
        d = (r >> 32) * {32'd0, adj} + (({32'd0, r[31:0]} * {32'd0, adj}) >> 32);
        if (d > 64'hFFFF_FFFF) begin
          clipped = 1'b1;
          d = 64'hFFFF_FFFF;
        end
        e.screen_depth = {1'b0, d[31:0]};
      end else begin
        e.screen_depth = {y[31], y};
      end
      e.screen_x = 32'(axis(x, sx, ox, r));
      e.screen_y = 32'(axis(z, sy, oy, r));
      e.status = clipped ? vsp_pkg::STAT_SAT : vsp_pkg::STAT_OK;
      pending.push_back(e);
    endfunction

    function void check_result(vsp_pkg::res_t got);
      vsp_pkg::res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: x=%h y=%h d=%h st=%0d",
                   got.screen_x, got.screen_y, got.screen_depth, got.status);
        return;
      end
      e = pending.pop_front();
      if (e.screen_x !== got.screen_x || e.screen_y !== got.screen_y ||
          e.screen_depth !== got.screen_depth || e.status !== got.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp x=%h y=%h d=%h st=%0d got x=%h y=%h d=%h st=%0d",
                   e.screen_x, e.screen_y, e.screen_depth, e.status,
                   got.screen_x, got.screen_y, got.screen_depth, got.status);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [31:0] cam_x, cam_depth, cam_up;
  logic        out_valid, out_stall;
  logic [31:0] screen_x, screen_y;
  logic [32:0] screen_depth;
  logic [1:0]  status;
  logic        psel, penable, pwrite;
  logic [vsp_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  projection_scoreboard sb;
  bit sender_idle, recv_stall;
  int idle_pct;
  int hold_left;
  int quiet_cycles;

  vertex_screen_projection_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cam_x <= '0;
    cam_depth <= '0;
    cam_up <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic setup(logic mode, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                       logic [31:0] d, logic [31:0] e);
    drain();
    write_reg(vsp_pkg::REG_MODE, {31'd0, mode});
    write_reg(vsp_pkg::REG_SCALE_X, a);
    write_reg(vsp_pkg::REG_SCALE_Y, b);
    write_reg(vsp_pkg::REG_OFFSET_X, c);
    write_reg(vsp_pkg::REG_OFFSET_Y, d);
    write_reg(vsp_pkg::REG_INV_Z, e);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    in_valid <= 1'b1;
    cam_x <= x;
    cam_depth <= y;
    cam_up <= z;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(x, y, z);
    gap = 0;
    if (sender_idle)
      while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: v = $urandom_range(1 << 20);
      2: v = -$urandom_range(1 << 20);
      3: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_depth();
    if (sb.persp && $urandom_range(99) < 80)
      return $urandom >> $urandom_range(1, 31);
    return pick_word();
  endfunction

  task automatic random_vertices(int n);
    for (int i = 0; i < n; i++)
      send_vertex(pick_word(), pick_depth(), pick_word());
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result('{screen_x: screen_x, screen_y: screen_y,
                          screen_depth: screen_depth, status: status});
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= recv_stall && ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    sender_idle = 0;
    recv_stall = 0;
    idle_pct = 87;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(32'h0001_0000, 32'd0, 32'h0001_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(32'h0000_0005, 32'hFFFF_FFFF, 32'd0);
    send_vertex(32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
    send_vertex(32'd1, 32'd1, 32'hFFFF_FFFF);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
    send_vertex(32'h0003_0000, 32'h00A0_0000, 32'hFFF0_0000);
    send_vertex(32'd0, 32'd2, 32'd0);
    setup(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
    send_vertex(32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_vertex(32'd0, 32'd5, 32'd0);

    setup(1'b1, 32'h0140_0000, 32'hFF10_0000, 32'h0140_0000, 32'h00F0_0000, 32'h0010_0000);
    hold_left = 400;
    random_vertices(150);

    sender_idle = 1;
    setup(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    random_vertices(150);

    sender_idle = 0;
    recv_stall = 1;
    setup(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_vertices(150);

    sender_idle = 1;
    setup(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
    idle_pct = 32;
    random_vertices(150);

    sender_idle = 0;
    recv_stall = 0;
    setup(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    idle_pct = 87;
    random_vertices(150);

    recv_stall = 1;
    setup(1'b1, $urandom_range(1 << 18), -$urandom_range(1 << 18), $urandom, $urandom,
          $urandom);
    random_vertices(75);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    recv_stall = 0;
    random_vertices(75);
    in_valid <= 1'b0;

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
